/* design/vrot_pkg.sv */
package vrot_pkg;

  // x/y carry 16 fractional bits; pre-rotation negation plus CORDIC gain
  // needs up to 35 bits, one more kept as headroom.
  localparam int XY_W = 36;
  // Residual angle, 2^32 units per turn, stays well inside +/-2^31.
  localparam int Z_W = 34;
  localparam int FRAC_BITS = 16;
  localparam int ATAN_LEN = 24;

  // Gain multiply split into a signed high part and an unsigned low part.
  localparam int LO_W = 18;
  localparam int HI_W = XY_W - LO_W;
  localparam int GAIN_W = 31;
  localparam int PH_W = HI_W + GAIN_W;
  localparam int PL_W = LO_W + GAIN_W - 1;
  localparam int SUM_W = 68;
  localparam int OUT_SHIFT = 46;

  localparam int OUT_W = 17;

  localparam logic signed [GAIN_W-1:0] GAIN_Q30 = 31'sd652032874;
  localparam logic signed [OUT_W-1:0] OUT_LIMIT = 17'sd46341;

  // atan(2^-i), 2^32 units per turn
  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vrot_vec_t;

endpackage

/* design/vrot_prerot.sv */
module vrot_prerot (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] turn_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vrot_pkg::vrot_vec_t out_vec_o
);
  import vrot_pkg::*;

  logic      valid_q;
  vrot_vec_t vec_d, vec_q;
  logic      flip;
  logic [15:0] ang;
  logic signed [XY_W-1:0] x_ext, y_ext;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_vec_o   = vec_q;

  // Angle outside [-pi/2, pi/2): turn by a half turn, i.e. negate x/y and
  // flip the angle's sign bit.
  always_comb begin
    flip  = turn_angle_i[15] ^ turn_angle_i[14];
    ang   = {turn_angle_i[15] ^ flip, turn_angle_i[14:0]};
    x_ext = XY_W'(vec_x_i) <<< FRAC_BITS;
    y_ext = XY_W'(vec_y_i) <<< FRAC_BITS;
    vec_d.x = flip ? -x_ext : x_ext;
    vec_d.y = flip ? -y_ext : y_ext;
    vec_d.z = Z_W'($signed({ang, 16'h0000}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      vec_q <= vec_d;
    end
  end

endmodule

/* design/vrot_micro.sv */
module vrot_micro #(
  parameter int STAGE = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vrot_pkg::vrot_vec_t in_vec_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vrot_pkg::vrot_vec_t out_vec_o
);
  import vrot_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN_STEP = Z_W'(ATAN_TAB[STAGE]);

  logic      valid_q;
  vrot_vec_t vec_d, vec_q;
  logic signed [XY_W-1:0] dx, dy;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_vec_o   = vec_q;

  always_comb begin
    dx = in_vec_i.y >>> STAGE;
    dy = in_vec_i.x >>> STAGE;
    if (!in_vec_i.z[Z_W-1]) begin
      vec_d.x = in_vec_i.x - dx;
      vec_d.y = in_vec_i.y + dy;
      vec_d.z = in_vec_i.z - ATAN_STEP;
    end else begin
      vec_d.x = in_vec_i.x + dx;
      vec_d.y = in_vec_i.y - dy;
      vec_d.z = in_vec_i.z + ATAN_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      vec_q <= vec_d;
    end
  end

endmodule

/* design/vrot_gain.sv */
module vrot_gain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vrot_pkg::vrot_vec_t in_vec_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [vrot_pkg::OUT_W-1:0] rot_x_o,
  output logic signed [vrot_pkg::OUT_W-1:0] rot_y_o
);
  import vrot_pkg::*;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (OUT_SHIFT - 1);
  localparam logic [GAIN_W-2:0] GAIN_U = GAIN_Q30[GAIN_W-2:0];

  // Partial products stage
  logic              prod_valid_q;
  logic              prod_ready;
  logic signed [PH_W-1:0] ph_x_d, ph_y_d, ph_x_q, ph_y_q;
  logic [PL_W-1:0]        pl_x_d, pl_y_d, pl_x_q, pl_y_q;

  // Output stage
  logic              out_valid_q;
  logic signed [OUT_W-1:0] rot_x_d, rot_y_d, rot_x_q, rot_y_q;

  function automatic logic signed [OUT_W-1:0] round_clamp(
    input logic signed [PH_W-1:0] ph,
    input logic [PL_W-1:0]        pl
  );
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] r;
    logic signed [OUT_W-1:0] res;
    sum = (SUM_W'(ph) <<< LO_W) + $signed(SUM_W'(pl)) + ROUND_HALF;
    r   = sum >>> OUT_SHIFT;
    if (r > SUM_W'(OUT_LIMIT)) begin
      res = OUT_LIMIT;
    end else if (r < -SUM_W'(OUT_LIMIT)) begin
      res = -OUT_LIMIT;
    end else begin
      res = r[OUT_W-1:0];
    end
    return res;
  endfunction

  assign prod_ready  = !out_valid_q || out_ready_i;
  assign in_ready_o  = !prod_valid_q || prod_ready;
  assign out_valid_o = out_valid_q;
  assign rot_x_o     = rot_x_q;
  assign rot_y_o     = rot_y_q;

  always_comb begin
    ph_x_d = $signed(in_vec_i.x[XY_W-1:LO_W]) * GAIN_Q30;
    ph_y_d = $signed(in_vec_i.y[XY_W-1:LO_W]) * GAIN_Q30;
    pl_x_d = in_vec_i.x[LO_W-1:0] * GAIN_U;
    pl_y_d = in_vec_i.y[LO_W-1:0] * GAIN_U;
    rot_x_d = round_clamp(ph_x_q, pl_x_q);
    rot_y_d = round_clamp(ph_y_q, pl_y_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_ready_o) begin
        prod_valid_q <= in_valid_i;
      end
      if (prod_ready) begin
        out_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ph_x_q <= ph_x_d;
      ph_y_q <= ph_y_d;
      pl_x_q <= pl_x_d;
      pl_y_q <= pl_y_d;
    end
    if (prod_ready && prod_valid_q) begin
      rot_x_q <= rot_x_d;
      rot_y_q <= rot_y_d;
    end
  end

endmodule

/* design/vector_rotate_2d.sv */
// vector_rotate_2d: rotates (vec_x_i, vec_y_i) counter-clockwise by the
// binary angle turn_angle_i (65536 units per turn, -32768 is minus pi).
// Result rot_x_o/rot_y_o is 17-bit signed, within about one LSB of exact.
//
// Channels: input and output each use valid/ready; a transfer happens on a
// rising edge with valid and ready both high.
//
// Pipeline: one register for the half-turn pre-rotation, one register per
// CORDIC micro-rotation (ITERATIONS of them), then two for the gain
// correction (partial products, then sum/round/clamp).
// Throughput: one vector per cycle as long as out_ready_i stays high.
//
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls, each stage holds its item and accepts a new one
// only into an empty slot, so the pipe fills up and in_ready_o drops once
// every stage is occupied. Nothing is dropped or repeated.
module vector_rotate_2d #(
  parameter int ITERATIONS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] turn_angle_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] rot_x_o,
  output logic signed [16:0] rot_y_o
);
  import vrot_pkg::*;

  vrot_vec_t stage_vec   [ITERATIONS+1];
  logic      stage_valid [ITERATIONS+1];
  logic      stage_ready [ITERATIONS+1];

  vrot_prerot u_prerot (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .vec_x_i      (vec_x_i),
    .vec_y_i      (vec_y_i),
    .turn_angle_i (turn_angle_i),
    .out_valid_o  (stage_valid[0]),
    .out_ready_i  (stage_ready[0]),
    .out_vec_o    (stage_vec[0])
  );

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_micro
    vrot_micro #(
      .STAGE (g)
    ) u_micro (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stage_valid[g]),
      .in_ready_o  (stage_ready[g]),
      .in_vec_i    (stage_vec[g]),
      .out_valid_o (stage_valid[g+1]),
      .out_ready_i (stage_ready[g+1]),
      .out_vec_o   (stage_vec[g+1])
    );
  end

  vrot_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stage_valid[ITERATIONS]),
    .in_ready_o  (stage_ready[ITERATIONS]),
    .in_vec_i    (stage_vec[ITERATIONS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rot_x_o     (rot_x_o),
    .rot_y_o     (rot_y_o)
  );

endmodule
